### rtl/esf_pkg.sv
// Shared types, constants and the arctangent table of the eclipse shadow fraction block.
`timescale 1ns / 1ps
package esf_pkg;

  localparam int AngleW      = 32;
  localparam int FracW       = 17;
  localparam int NormW       = 31;
  localparam int SumW        = 34;
  localparam int CordicIters = 30;
  localparam int SqrtIters   = 32;
  localparam int DivIters    = 16;
  localparam int MulSteps1   = 6;
  localparam int MulSteps2   = 4;
  localparam int QueueDepth  = 4;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCntW       = $clog2(QueueDepth + 1);

  localparam logic [FracW-1:0]   FracFull  = 17'h10000;
  localparam logic [FracW-1:0]   FracNone  = 17'h00000;
  localparam logic [31:0]        PiQ30     = 32'd3373259426;
  localparam logic signed [32:0] HalfPiQ30 = 33'sd1686629713;

  typedef enum logic [1:0] {
    REG_SUNLIT   = 2'd0,
    REG_UMBRA    = 2'd1,
    REG_PENUMBRA = 2'd2
  } region_t;

  typedef struct packed {
    logic [AngleW-1:0] earth_radius_angle;
    logic [AngleW-1:0] sun_radius_angle;
    logic [AngleW-1:0] separation_angle;
  } item_t;

  typedef struct packed {
    logic [FracW-1:0] shadow_fraction;
    region_t          region;
  } result_t;

  // classified and normalized work passed from front to back
  typedef struct packed {
    region_t          region;
    logic [NormW-1:0] a;
    logic [NormW-1:0] b;
    logic [NormW-1:0] c;
    logic [NormW-1:0] d;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL1,
    B_SQRT,
    B_CINIT,
    B_CORDIC,
    B_MUL2,
    B_SUM,
    B_KITE,
    B_CMP,
    B_DIV,
    B_DONE
  } back_state_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] t;
    unique case (i)
      5'd0:  t = 30'd843314856;
      5'd1:  t = 30'd497837829;
      5'd2:  t = 30'd263043836;
      5'd3:  t = 30'd133525158;
      5'd4:  t = 30'd67021686;
      5'd5:  t = 30'd33543515;
      5'd6:  t = 30'd16775850;
      5'd7:  t = 30'd8388437;
      5'd8:  t = 30'd4194282;
      5'd9:  t = 30'd2097149;
      5'd10: t = 30'd1048575;
      5'd11: t = 30'd524287;
      5'd12: t = 30'd262143;
      5'd13: t = 30'd131071;
      5'd14: t = 30'd65535;
      5'd15: t = 30'd32767;
      5'd16: t = 30'd16383;
      5'd17: t = 30'd8191;
      5'd18: t = 30'd4095;
      5'd19: t = 30'd2047;
      5'd20: t = 30'd1023;
      5'd21: t = 30'd511;
      5'd22: t = 30'd255;
      5'd23: t = 30'd127;
      5'd24: t = 30'd63;
      5'd25: t = 30'd31;
      5'd26: t = 30'd15;
      5'd27: t = 30'd7;
      5'd28: t = 30'd3;
      5'd29: t = 30'd1;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

endpackage

### rtl/esf_front.sv
// Front end: accepts items, classifies the overlap and normalizes the lens factors.
`timescale 1ns / 1ps
module esf_front import esf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  input  logic    full,
  output logic    push,
  output job_t    job
);

  logic                  s1_valid;
  region_t               s1_region;
  logic [SumW-1:0]       s1_a, s1_b, s1_c, s1_d;

  logic [AngleW:0]       sum_es;
  logic [AngleW-1:0]     diff_es;
  logic                  apart, contained, accept;
  logic [SumW-1:0]       e_x, s_x, l_x;
  logic [5:0]            msb;
  logic                  shift_right;
  logic [5:0]            rsh, lsh;

  assign e_x     = SumW'(item.earth_radius_angle);
  assign s_x     = SumW'(item.sun_radius_angle);
  assign l_x     = SumW'(item.separation_angle);
  assign sum_es  = {1'b0, item.earth_radius_angle} + {1'b0, item.sun_radius_angle};
  assign diff_es = (item.earth_radius_angle > item.sun_radius_angle) ?
                   item.earth_radius_angle - item.sun_radius_angle :
                   item.sun_radius_angle - item.earth_radius_angle;
  assign apart     = {1'b0, item.separation_angle} >= sum_es;
  assign contained = item.separation_angle <= diff_es;

  assign item_stall = s1_valid && full;
  assign accept     = item_valid && !item_stall;
  assign push       = s1_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_region <= apart ? REG_SUNLIT : (contained ? REG_UMBRA : REG_PENUMBRA);
      s1_a      <= SumW'(sum_es) - l_x;
      s1_b      <= l_x + s_x - e_x;
      s1_c      <= l_x + e_x - s_x;
      s1_d      <= l_x + e_x + s_x;
    end
  end

  // bring d into [2^30, 2^31); right shifts truncate
  always_comb begin
    msb = 6'd0;
    for (int i = 0; i < SumW; i++) begin
      if (s1_d[i]) msb = 6'(i);
    end
  end

  assign shift_right = msb > 6'(NormW - 1);
  assign rsh         = msb - 6'(NormW - 1);
  assign lsh         = 6'(NormW - 1) - msb;

  function automatic logic [NormW-1:0] norm(input logic [SumW-1:0] x, input logic rt,
                                            input logic [5:0] r, input logic [5:0] l);
    logic [SumW-1:0] y;
    y = rt ? (x >> r) : (x << l);
    return y[NormW-1:0];
  endfunction

  assign job.region = s1_region;
  assign job.a      = norm(s1_a, shift_right, rsh, lsh);
  assign job.b      = norm(s1_b, shift_right, rsh, lsh);
  assign job.c      = norm(s1_c, shift_right, rsh, lsh);
  assign job.d      = norm(s1_d, shift_right, rsh, lsh);

endmodule

### rtl/esf_queue.sv
// Short job queue between front and back ends.
`timescale 1ns / 1ps
module esf_queue import esf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t             slots [QueueDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign full    = count == QCntW'(QueueDepth);
  assign empty   = count == '0;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

### rtl/esf_back.sv
// Back end: square roots, CORDIC angles, lens area and the fraction divider.
`timescale 1ns / 1ps
module esf_back import esf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    empty,
  input  job_t    pop_job,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  back_state_t state, state_next;
  logic [4:0]  cnt;
  logic        cnt_last;

  logic [NormW-1:0] na, nb, nc, nd;
  logic [31:0]      e2, s2;
  logic [63:0]      eesq, sssq;

  logic [62:0]             sq_v [4];
  logic [62:0]             sq_r [4];
  logic [62:0]             sq_try [4];
  logic                    sq_take [4];
  logic [62:0]             sq_bit;
  logic [4:0]              sq_pos;

  logic signed [34:0] cx [2];
  logic signed [34:0] cy [2];
  logic signed [32:0] cz [2];
  logic signed [34:0] dx [2];
  logic signed [34:0] dy [2];
  logic signed [32:0] tab;
  logic signed [32:0] clamp [2];
  logic [31:0]        alpha, beta;

  logic [32:0] op_a, op_b;
  logic [65:0] prod;
  logic [65:0] p1, p2, kite, den;
  logic [66:0] hacc;
  logic [65:0] rem;
  logic [66:0] rem_sh;
  logic [15:0] quo;
  logic [FracW-1:0] frac;
  region_t     region;

  assign e2 = {1'b0, na} + {1'b0, nc};
  assign s2 = {1'b0, na} + {1'b0, nb};

  always_comb begin
    unique case (state)
      B_MUL1:   cnt_last = cnt == 5'(MulSteps1 - 1);
      B_SQRT:   cnt_last = cnt == 5'(SqrtIters - 1);
      B_CORDIC: cnt_last = cnt == 5'(CordicIters - 1);
      B_MUL2:   cnt_last = cnt == 5'(MulSteps2 - 1);
      B_DIV:    cnt_last = cnt == 5'(DivIters - 1);
      default:  cnt_last = 1'b0;
    endcase
  end

  // shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state == B_MUL1) begin
      case (cnt)
        5'd0:    begin op_a = 33'(na); op_b = 33'(nb); end
        5'd1:    begin op_a = 33'(nc); op_b = 33'(nd); end
        5'd2:    begin op_a = 33'(na); op_b = 33'(nc); end
        5'd3:    begin op_a = 33'(nb); op_b = 33'(nd); end
        5'd4:    begin op_a = 33'(e2); op_b = 33'(e2); end
        default: begin op_a = 33'(s2); op_b = 33'(s2); end
      endcase
    end else if (state == B_MUL2) begin
      case (cnt)
        5'd0:    begin op_a = eesq[63:31]; op_b = 33'(alpha); end
        5'd1:    begin op_a = sssq[63:31]; op_b = 33'(beta); end
        5'd2:    begin op_a = 33'(sq_r[0][31:0]); op_b = 33'(sq_r[1][31:0]); end
        default: begin op_a = sssq[63:31]; op_b = 33'(PiQ30); end
      endcase
    end
  end
  assign prod = op_a * op_b;

  // bit-at-a-time square roots, four units side by side
  assign sq_pos = 5'(SqrtIters - 1) - cnt;
  assign sq_bit = 63'd1 << {sq_pos, 1'b0};
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sq_try[k]  = sq_r[k] + sq_bit;
      sq_take[k] = sq_v[k] >= sq_try[k];
    end
  end

  // vectoring CORDIC, two units side by side
  assign tab = $signed({3'b000, atan_entry(cnt)});
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      dx[k] = cy[k] >>> cnt;
      dy[k] = cx[k] >>> cnt;
      if (cz[k] < 0)              clamp[k] = '0;
      else if (cz[k] > HalfPiQ30) clamp[k] = HalfPiQ30;
      else                        clamp[k] = cz[k];
    end
  end
  assign alpha = {clamp[0][30:0], 1'b0};
  assign beta  = {clamp[1][30:0], 1'b0};

  assign rem_sh = {rem, 1'b0};
  assign pop    = (state == B_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (!empty) state_next = (pop_job.region == REG_PENUMBRA) ? B_MUL1 : B_DONE;
      B_MUL1:   if (cnt_last) state_next = B_SQRT;
      B_SQRT:   if (cnt_last) state_next = B_CINIT;
      B_CINIT:  state_next = B_CORDIC;
      B_CORDIC: if (cnt_last) state_next = B_MUL2;
      B_MUL2:   if (cnt_last) state_next = B_SUM;
      B_SUM:    state_next = B_KITE;
      B_KITE:   state_next = B_CMP;
      B_CMP:    state_next = (hacc >= {1'b0, den}) ? B_DONE : B_DIV;
      B_DIV:    if (cnt_last) state_next = B_DONE;
      B_DONE:   if (!result_valid || !result_stall) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (cnt_last || state == B_IDLE) cnt <= '0;
    else if (state == B_MUL1 || state == B_SQRT || state == B_CORDIC ||
             state == B_MUL2 || state == B_DIV) cnt <= cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        na     <= pop_job.a;
        nb     <= pop_job.b;
        nc     <= pop_job.c;
        nd     <= pop_job.d;
        region <= pop_job.region;
        frac   <= (pop_job.region == REG_UMBRA) ? FracFull : FracNone;
        for (int k = 0; k < 4; k++) sq_r[k] <= '0;
      end
      B_MUL1: begin
        if (cnt < 5'd4)       sq_v[cnt[1:0]] <= {1'b0, prod[61:0]};
        else if (cnt == 5'd4) eesq <= prod[63:0];
        else                  sssq <= prod[63:0];
      end
      B_SQRT: begin
        for (int k = 0; k < 4; k++) begin
          if (sq_take[k]) begin
            sq_v[k] <= sq_v[k] - sq_try[k];
            sq_r[k] <= (sq_r[k] >> 1) + sq_bit;
          end else begin
            sq_r[k] <= sq_r[k] >> 1;
          end
        end
      end
      B_CINIT: begin
        cy[0] <= $signed(35'(sq_r[0][31:0]));
        cx[0] <= $signed(35'(sq_r[1][31:0]));
        cy[1] <= $signed(35'(sq_r[2][31:0]));
        cx[1] <= $signed(35'(sq_r[3][31:0]));
        cz[0] <= '0;
        cz[1] <= '0;
      end
      B_CORDIC: begin
        for (int k = 0; k < 2; k++) begin
          if (!cy[k][34]) begin
            cx[k] <= cx[k] + dx[k];
            cy[k] <= cy[k] - dy[k];
            cz[k] <= cz[k] + tab;
          end else begin
            cx[k] <= cx[k] - dx[k];
            cy[k] <= cy[k] + dy[k];
            cz[k] <= cz[k] - tab;
          end
        end
      end
      B_MUL2: begin
        case (cnt)
          5'd0:    p1   <= prod;
          5'd1:    p2   <= prod;
          5'd2:    kite <= prod;
          default: den  <= prod;
        endcase
      end
      B_SUM:  hacc <= {1'b0, p1} + {1'b0, p2};
      B_KITE: hacc <= (hacc > {1'b0, kite}) ? hacc - {1'b0, kite} : '0;
      B_CMP: begin
        rem  <= hacc[65:0];
        quo  <= '0;
        frac <= FracFull;
      end
      B_DIV: begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= 66'(rem_sh - {1'b0, den});
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= rem_sh[65:0];
          quo <= {quo[14:0], 1'b0};
        end
        if (cnt_last) frac <= {1'b0, quo[14:0], (rem_sh >= {1'b0, den})};
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == B_DONE && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_DONE && (!result_valid || !result_stall)) begin
      result.shadow_fraction <= frac;
      result.region          <= region;
    end
  end

endmodule

### rtl/eclipse_shadow_fraction_core.sv
// Top level of the eclipse shadow fraction block.
// Sunlit and full-shadow items go straight to the result register; penumbra items run
//   the back end sequence of 6 multiplies, 32 root steps, 30 CORDIC steps, 4 multiplies
//   and 16 divide steps, the divide being skipped when the lens covers the whole Sun.
// The back end starts the next item only when it is through with the last one.
// Reset: synchronous, active high; clears the queue, the sequencer and result valid.
`timescale 1ns / 1ps
module eclipse_shadow_fraction_core import esf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // front end -> queue
  logic push, full;
  job_t push_job;
  // queue -> back end
  logic pop, empty;
  job_t pop_job;

  // Front: one input transaction per cycle while the queue has room. Classifies
  // apart / contained / lens and normalizes the four lens factors.
  esf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .full       (full),
    .push       (push),
    .job        (push_job)
  );

  // Four-deep queue lets the front keep taking transactions while the back works.
  esf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  // Back: sequencer around one shared multiplier, root units, CORDIC units and
  // a restoring divider; its output register frees it for the next job.
  esf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop_job      (pop_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### rtl/esf_checker.sv
// Port-level checks for the eclipse shadow fraction block and their bind.
`timescale 1ns / 1ps
module esf_port_checks import esf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_sunlit_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.region == REG_SUNLIT |-> result.shadow_fraction == FracNone)
    else $error("sunlit result with nonzero fraction");

  a_umbra_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.region == REG_UMBRA |-> result.shadow_fraction == FracFull)
    else $error("full shadow result not fully covered");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.shadow_fraction <= FracFull)
    else $error("fraction above full scale");

endmodule

bind eclipse_shadow_fraction_core esf_port_checks u_esf_port_checks (.*);

### verif/esf_checker.sv
// Checker for the eclipse shadow fraction block: predicts each result and compares it.
`timescale 1ns / 1ps
module esf_checker import esf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      fail_count,
  output int      pending_count
);

  result_t expected_q[$];

  function automatic longint signed fshr(longint signed v, int sh);
    return v >>> sh;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    r = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] vector_angle(logic [63:0] y0, logic [63:0] x0);
    longint signed x;
    longint signed y;
    longint signed ang;
    longint signed dx;
    longint signed dy;
    x = x0;
    y = y0;
    ang = '0;
    for (int i = 0; i < CordicIters; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; ang += longint'(atan_entry(i[4:0]));
      end else begin
        x -= dx; y += dy; ang -= longint'(atan_entry(i[4:0]));
      end
    end
    if (ang < 0) ang = '0;
    if (ang > longint'(HalfPiQ30)) ang = longint'(HalfPiQ30);
    return ang;
  endfunction

  function automatic logic [16:0] lens_fraction(logic [63:0] e, logic [63:0] s, logic [63:0] l);
    logic [63:0] a, b, c, d, e2, s2, u, v, w, z, alpha, beta, h, den, kite, rem, q;
    a = e + s - l; b = l + s - e; c = l + e - s; d = l + e + s;
    while (d >= (64'd1 << 31)) begin
      a >>= 1; b >>= 1; c >>= 1; d >>= 1;
    end
    while (d < (64'd1 << 30)) begin
      a <<= 1; b <<= 1; c <<= 1; d <<= 1;
    end
    e2 = a + c;
    s2 = a + b;
    u = root_floor(a * b);
    v = root_floor(c * d);
    w = root_floor(a * c);
    z = root_floor(b * d);
    alpha = 64'd2 * vector_angle(u, v);
    beta = 64'd2 * vector_angle(w, z);
    h = ((e2 * e2) >> 31) * alpha + ((s2 * s2) >> 31) * beta;
    kite = u * v;
    h = (h > kite) ? h - kite : 64'd0;
    den = ((s2 * s2) >> 31) * 64'(PiQ30);
    if (h >= den) return FracFull;
    rem = h;
    q = '0;
    for (int i = 0; i < DivIters; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= den) begin
        rem -= den;
        q[0] = 1'b1;
      end
    end
    return q[16:0];
  endfunction

  function automatic result_t predict_shadow(item_t it);
    result_t r;
    logic [63:0] e, s, l, diff;
    e = 64'(it.earth_radius_angle);
    s = 64'(it.sun_radius_angle);
    l = 64'(it.separation_angle);
    diff = (e > s) ? e - s : s - e;
    if (l >= e + s) begin
      r.shadow_fraction = FracNone;
      r.region = REG_SUNLIT;
    end else if (l <= diff) begin
      r.shadow_fraction = FracFull;
      r.region = REG_UMBRA;
    end else begin
      r.shadow_fraction = lens_fraction(e, s, l);
      r.region = REG_PENUMBRA;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (item_valid && !item_stall) expected_q.push_back(predict_shadow(item));
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: fraction %0d region %0d",
                 result.shadow_fraction, result.region);
          errs = errs + 1;
        end else begin
          want = expected_q.pop_front();
          if (result.shadow_fraction !== want.shadow_fraction) begin
            $error("shadow_fraction expected %0d actual %0d",
                   want.shadow_fraction, result.shadow_fraction);
            errs = errs + 1;
          end
          if (result.region !== want.region) begin
            $error("region expected %0d actual %0d", want.region, result.region);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending_count <= expected_q.size();
  end

endmodule

### verif/tb_top.sv
// Testbench top for the eclipse shadow fraction block: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;
  import esf_pkg::*;

  localparam int RandomItems = 1100;
  localparam int WatchdogLimit = 4000;   // covers a penumbra item plus the longest receiver stall, many times over
  localparam logic [31:0] HalfPi = 32'd1686629713;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  int      fail_count;
  int      pending_count;
  int      quiet_cycles = 0;
  bit      calm = 1'b0;       // no idling in the final stretch

  always #4 clk = ~clk;

  eclipse_shadow_fraction_core i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  esf_checker i_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver backpressure: random bursts of stall, off once the run is calm
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // One transaction; valid stays up across back-to-back items
  task automatic send_angles(logic [31:0] e, logic [31:0] s, logic [31:0] l);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 9);
      item_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= '{earth_radius_angle: e, sun_radius_angle: s, separation_angle: l};
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // Small Sun radius mostly, Earth radius small or large; partial overlap most of the time
  task automatic send_random;
    logic [31:0] e, s, l, lo, hi;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      send_angles($urandom, $urandom, $urandom);
    end else begin
      e = (pick < 5) ? $urandom_range(1, 32'h0100_0000) : $urandom_range(1, 32'h7fff_ffff);
      s = (pick < 8) ? $urandom_range(1, 32'h0100_0000) : $urandom;
      e = e | ($urandom_range(0, 1) << $urandom_range(0, 31));
      lo = (e > s) ? e - s : s - e;
      hi = (64'(e) + s > 64'hffff_ffff) ? 32'hffff_ffff : e + s;
      if ($urandom_range(0, 7) == 0) l = $urandom_range(0, lo);
      else if ($urandom_range(0, 7) == 0) l = $urandom_range(hi, 32'hffff_ffff);
      else l = $urandom_range(lo, hi);
      send_angles(e, s, l);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: field extremes, each region, boundaries, Sun larger, tiny Sun
    send_angles(32'd0, 32'd0, 32'd0);
    send_angles(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_angles(32'hffff_ffff, 32'hffff_ffff, 32'd0);
    send_angles(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001);
    send_angles(32'd0, 32'd0, 32'hffff_ffff);
    send_angles(32'h0100_0000, 32'h0080_0000, 32'h0180_0000);  // touching outside
    send_angles(32'h0100_0000, 32'h0080_0000, 32'h017f_ffff);
    send_angles(32'h0100_0000, 32'h0080_0000, 32'h0080_0000);  // touching inside
    send_angles(32'h0100_0000, 32'h0080_0000, 32'h0080_0001);
    send_angles(32'h0080_0000, 32'h0100_0000, 32'h0010_0000);  // Sun larger, contained
    send_angles(32'h0080_0000, 32'h0100_0000, 32'h00c0_0000);  // Sun larger, partial
    send_angles(32'h0100_0000, 32'h0100_0000, 32'd1);          // nearly full coverage
    send_angles(32'h0100_0000, 32'h0100_0000, 32'h01ff_ffff);  // sliver
    send_angles(32'h7fff_ffff, 32'd1, 32'h7fff_ffff);          // tiny Sun, divider denominator may be 0
    send_angles(32'd1, 32'd1, 32'd1);
    send_angles(32'd2, 32'd1, 32'd2);
    send_angles(HalfPi, HalfPi, HalfPi);                       // wide lens angles
    send_angles(32'h8000_0000, 32'h4000_0000, 32'hb000_0000);
    send_angles(32'h0000_ffff, 32'h0000_a000, 32'h0000_c000);
    send_angles(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5556);
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - 100) calm = 1'b1;
      send_random();
    end
    item_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
